/* rtl/imuty_pkg.sv */
package imuty_pkg;

    // cordic datapath widths
    localparam int TAB_LEN           = 24;
    localparam int DEF_CORDIC_STEPS  = 16;
    localparam int XW                = 27;
    localparam int ZW                = 25;
    localparam int MW                = 25;

    localparam logic signed [ZW-1:0] HALF_TURN    = 25'sd5898240;
    localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
    localparam logic signed [17:0]   ANGLE_LIMIT  = 18'sd46080;
    localparam logic signed [17:0]   ROLL_LIMIT   = 18'sd23040;
    localparam logic signed [17:0]   PITCH_LIMIT  = 18'sd11520;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PITCH_OFFSET  = 3'd0,
        CFG_ROLL_OFFSET   = 3'd1,
        CFG_FILTER_ALPHA  = 3'd2,
        CFG_GYRO_DEADBAND = 3'd3,
        CFG_YAW_GAIN      = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] ALPHA_RST    = 16'd9830;
    localparam logic [14:0] DEADBAND_RST = 15'd66;
    localparam logic [23:0] GAIN_RST     = 24'd32786;

    // arctangent of 2^-i in 1/32768 degree
    function automatic logic [20:0] atan_entry(input logic [4:0] idx);
        logic [20:0] v;
        unique case (idx)
            5'd0:  v = 21'd1474560;
            5'd1:  v = 21'd870484;
            5'd2:  v = 21'd459940;
            5'd3:  v = 21'd233473;
            5'd4:  v = 21'd117189;
            5'd5:  v = 21'd58652;
            5'd6:  v = 21'd29333;
            5'd7:  v = 21'd14667;
            5'd8:  v = 21'd7334;
            5'd9:  v = 21'd3667;
            5'd10: v = 21'd1833;
            5'd11: v = 21'd917;
            5'd12: v = 21'd458;
            5'd13: v = 21'd229;
            5'd14: v = 21'd115;
            5'd15: v = 21'd57;
            5'd16: v = 21'd29;
            5'd17: v = 21'd14;
            5'd18: v = 21'd7;
            5'd19: v = 21'd4;
            5'd20: v = 21'd2;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/imuty_in_if.sv */
interface imuty_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_z;
    logic [15:0]        elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_z, elapsed_ms,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_z, elapsed_ms,
                  output ready);
endinterface

/* rtl/imuty_out_if.sv */
interface imuty_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pitch;
    logic signed [16:0] roll;
    logic signed [31:0] yaw;
    logic [15:0]        gforce;

    modport source (output valid, pitch, roll, yaw, gforce, input ready);
    modport sink (input valid, pitch, roll, yaw, gforce, output ready);
endinterface

/* rtl/imuty_cordic.sv */
module imuty_cordic #(
    parameter int CORDIC_STEPS = imuty_pkg::DEF_CORDIC_STEPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [imuty_pkg::XW-1:0]  i_x,
    input  logic signed [imuty_pkg::XW-1:0]  i_y,
    output logic                             o_done,
    output logic [imuty_pkg::MW-1:0]         o_mag,
    output logic signed [imuty_pkg::ZW-1:0]  o_angle
);
    localparam int NSTEP = (CORDIC_STEPS < imuty_pkg::TAB_LEN) ? CORDIC_STEPS
                                                               : imuty_pkg::TAB_LEN;

    logic                            r_busy;
    logic                            r_done;
    logic [4:0]                      r_i;
    logic signed [imuty_pkg::XW-1:0] r_x;
    logic signed [imuty_pkg::XW-1:0] r_y;
    logic signed [imuty_pkg::ZW-1:0] r_z;

    logic signed [imuty_pkg::XW-1:0] n_xs;
    logic signed [imuty_pkg::XW-1:0] n_ys;
    logic signed [imuty_pkg::ZW-1:0] n_at;

    // one micro-rotation per cycle
    always_comb begin
        n_xs = r_x >>> r_i;
        n_ys = r_y >>> r_i;
        n_at = $signed({4'b0000, imuty_pkg::atan_entry(r_i)});
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_done <= (i_start && i_x == '0 && i_y == '0) ||
                      (!i_start && r_busy && r_i == 5'(NSTEP - 1));
            if (i_start) begin
                r_i <= 5'd0;
                if (!(i_x == '0 && i_y == '0)) begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // vector datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_x == '0 && i_y == '0) begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else if (i_x[imuty_pkg::XW-1]) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= i_y[imuty_pkg::XW-1] ? -imuty_pkg::HALF_TURN : imuty_pkg::HALF_TURN;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (!r_y[imuty_pkg::XW-1]) begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_at;
            end else begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_at;
            end
        end
    end

    assign o_done  = r_done;
    assign o_mag   = r_x[imuty_pkg::MW-1:0];
    assign o_angle = r_z;
endmodule

/* rtl/imu_tilt_yaw_estimator.sv */
// sequence: an accepted request runs the shared cordic unit twice (roll pass,
// then pitch pass), each followed by gain compensation, then filter and yaw
// multiplier steps; a zero vector skips the micro-rotations of a pass
// a new request is taken only in idle, once the previous result is loaded;
// a result still held at the output stalls the sequencer in its last state
// reset: synchronous active low; clears angles and yaw, config to defaults
module imu_tilt_yaw_estimator #(
    parameter int CORDIC_STEPS = imuty_pkg::DEF_CORDIC_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    imuty_in_if.sink             i_in,
    imuty_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ROLL  = 11'b00000000010,
        S_CMP1  = 11'b00000000100,
        S_PITCH = 11'b00000001000,
        S_CMP2  = 11'b00000010000,
        S_MULP  = 11'b00000100000,
        S_UPDP  = 11'b00001000000,
        S_MULR  = 11'b00010000000,
        S_UPDR  = 11'b00100000000,
        S_YAW   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic   r_start;
    logic   r_yaw_ph;

    // configuration
    logic signed [14:0] r_pitch_off;
    logic signed [15:0] r_roll_off;
    logic [15:0]        r_alpha;
    logic [14:0]        r_deadband;
    logic [23:0]        r_gain;

    // sample and working registers
    logic signed [15:0] r_ax, r_ay, r_az, r_gz;
    logic [15:0]        r_ms;
    logic [imuty_pkg::MW-1:0]        r_mag;
    logic [imuty_pkg::MW-1:0]        r_m1;
    logic [imuty_pkg::MW-1:0]        r_m2;
    logic signed [imuty_pkg::ZW-1:0] r_roll_z;
    logic signed [imuty_pkg::ZW-1:0] r_pitch_z;
    logic signed [35:0] r_prod;
    logic signed [32:0] r_gms;
    logic signed [56:0] r_yprod;

    // state
    logic signed [16:0] r_fp, r_fr;
    logic signed [47:0] r_acc;

    // result register
    logic               r_out_valid;
    logic signed [16:0] r_o_pitch, r_o_roll;
    logic signed [31:0] r_o_yaw;
    logic [15:0]        r_o_gforce;

    logic                             w_cdone;
    logic [imuty_pkg::MW-1:0]         w_cmag;
    logic signed [imuty_pkg::ZW-1:0]  w_cang;
    logic signed [imuty_pkg::XW-1:0]  n_cx, n_cy;

    imuty_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_x     (n_cx),
        .i_y     (n_cy),
        .o_done  (w_cdone),
        .o_mag   (w_cmag),
        .o_angle (w_cang)
    );

    // cordic operand select: roll pass then pitch pass
    always_comb begin
        if (r_state == S_PITCH) begin
            n_cx = imuty_pkg::XW'($signed({1'b0, r_m1}));
            n_cy = -imuty_pkg::XW'($signed({r_ax, 8'h00}));
        end else begin
            n_cx = imuty_pkg::XW'($signed({r_az, 8'h00}));
            n_cy = imuty_pkg::XW'($signed({r_ay, 8'h00}));
        end
    end

    function automatic logic signed [17:0] clamp18(input logic signed [20:0] v,
                                                   input logic signed [17:0] lim);
        logic signed [17:0] r;
        if (v > 21'(lim)) begin
            r = lim;
        end else if (v < -21'(lim)) begin
            r = -lim;
        end else begin
            r = 18'(v);
        end
        return r;
    endfunction

    // cordic angle to 1/128 degree with range clamp
    function automatic logic signed [17:0] to_deg(input logic signed [24:0] z,
                                                  input logic signed [17:0] lim);
        logic signed [25:0] t;
        t = 26'(z) + 26'sd128;
        return clamp18(21'(t >>> 8), lim);
    endfunction

    // gain compensation, rounded
    function automatic logic [24:0] compensate(input logic [24:0] m);
        logic [55:0] p;
        p = 56'(m) * 56'(imuty_pkg::INV_GAIN_Q30) + 56'(30'd536870912);
        return p[54:30];
    endfunction

    logic signed [17:0] n_pitch_a, n_roll_a, n_raw;
    logic signed [16:0] n_f;
    logic signed [18:0] n_diff;
    logic signed [36:0] n_rnd;
    logic signed [20:0] n_upd;
    logic signed [16:0] n_newf;
    logic signed [16:0] n_gabs;
    logic signed [48:0] n_inc;
    logic signed [49:0] n_sum;
    logic signed [47:0] n_acc;
    logic [25:0]        n_gt;

    // filter operand path, shared by pitch and roll
    always_comb begin
        n_pitch_a = to_deg(r_pitch_z, imuty_pkg::PITCH_LIMIT);
        n_roll_a  = to_deg(r_roll_z, imuty_pkg::ROLL_LIMIT);
        if (r_state == S_MULP || r_state == S_UPDP) begin
            n_raw = clamp18(21'(n_pitch_a) - 21'(r_pitch_off), imuty_pkg::ANGLE_LIMIT);
            n_f   = r_fp;
        end else begin
            n_raw = clamp18(21'(n_roll_a) - 21'(r_roll_off), imuty_pkg::ANGLE_LIMIT);
            n_f   = r_fr;
        end
        n_diff = 19'(n_raw) - 19'(n_f);
        n_rnd  = 37'(r_prod) + 37'sd32768;
        n_upd  = 21'(n_f) + 21'(n_rnd >>> 16);
        n_newf = 17'(clamp18(n_upd, imuty_pkg::ANGLE_LIMIT));
    end

    // yaw integration and magnitude rounding
    always_comb begin
        n_gabs = r_gz[15] ? -17'(r_gz) : 17'(r_gz);
        n_inc  = 49'((58'(r_yprod) + 58'sd128) >>> 8);
        n_sum  = 50'(r_acc) + 50'(n_inc);
        if (n_sum > 50'sh0_7FFF_FFFF_FFFF) begin
            n_acc = 48'sh7FFF_FFFF_FFFF;
        end else if (n_sum < -50'sh0_8000_0000_0000) begin
            n_acc = 48'sh8000_0000_0000;
        end else begin
            n_acc = 48'(n_sum);
        end
        n_gt = 26'(r_m2) + 26'd128;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_off <= '0;
            r_roll_off  <= '0;
            r_alpha     <= imuty_pkg::ALPHA_RST;
            r_deadband  <= imuty_pkg::DEADBAND_RST;
            r_gain      <= imuty_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imuty_pkg::CFG_PITCH_OFFSET:  r_pitch_off <= i_cfg_data[14:0];
                imuty_pkg::CFG_ROLL_OFFSET:   r_roll_off  <= i_cfg_data[15:0];
                imuty_pkg::CFG_FILTER_ALPHA:  r_alpha     <= i_cfg_data[15:0];
                imuty_pkg::CFG_GYRO_DEADBAND: r_deadband  <= i_cfg_data[14:0];
                imuty_pkg::CFG_YAW_GAIN:      r_gain      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_yaw_ph    <= 1'b0;
            r_fp        <= '0;
            r_fr        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= (r_state == S_IDLE && i_in.valid) || (r_state == S_CMP1);
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_ROLL;
                    end
                end
                S_ROLL: begin
                    if (w_cdone) begin
                        r_state <= S_CMP1;
                    end
                end
                S_CMP1: r_state <= S_PITCH;
                S_PITCH: begin
                    if (w_cdone) begin
                        r_state <= S_CMP2;
                    end
                end
                S_CMP2: r_state <= S_MULP;
                S_MULP: r_state <= S_UPDP;
                S_UPDP: begin
                    r_fp    <= n_newf;
                    r_state <= S_MULR;
                end
                S_MULR: r_state <= S_UPDR;
                S_UPDR: begin
                    r_fr     <= n_newf;
                    r_yaw_ph <= 1'b0;
                    r_state  <= S_YAW;
                end
                S_YAW: begin
                    r_yaw_ph <= 1'b1;
                    if (r_yaw_ph) begin
                        if (n_gabs > $signed({2'b00, r_deadband})) begin
                            r_acc <= n_acc;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_ax <= i_in.accel_x;
            r_ay <= i_in.accel_y;
            r_az <= i_in.accel_z;
            r_gz <= i_in.gyro_z;
            r_ms <= i_in.elapsed_ms;
        end
        if ((r_state == S_ROLL || r_state == S_PITCH) && w_cdone) begin
            r_mag <= w_cmag;
            if (r_state == S_ROLL) begin
                r_roll_z <= w_cang;
            end else begin
                r_pitch_z <= w_cang;
            end
        end
        if (r_state == S_CMP1) begin
            r_m1 <= compensate(r_mag);
        end
        if (r_state == S_CMP2) begin
            r_m2 <= compensate(r_mag);
        end
        if (r_state == S_MULP || r_state == S_MULR) begin
            r_prod <= 36'(n_diff) * 36'($signed({1'b0, r_alpha}));
        end
        if (r_state == S_UPDR) begin
            r_gms <= 33'(r_gz) * 33'($signed({1'b0, r_ms}));
        end
        if (r_state == S_YAW && !r_yaw_ph) begin
            r_yprod <= 57'(r_gms) * 57'($signed({1'b0, r_gain}));
        end
        if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
            r_o_pitch  <= r_fp;
            r_o_roll   <= r_fr;
            r_o_yaw    <= r_acc[47:16];
            r_o_gforce <= (n_gt[25:24] != 2'b00) ? 16'hFFFF : n_gt[23:8];
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.pitch  = r_o_pitch;
    assign o_out.roll   = r_o_roll;
    assign o_out.yaw    = r_o_yaw;
    assign o_out.gforce = r_o_gforce;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_ROLL && r_start))
        else $error("accepted request did not start the roll pass");

    a_done_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == S_ROLL || r_state == S_PITCH))
        else $error("cordic finished outside a vectoring pass");

    a_filt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fp <= 17'sd46080 && r_fp >= -17'sd46080 &&
         r_fr <= 17'sd46080 && r_fr >= -17'sd46080))
        else $error("filtered angle out of range");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || o_out.ready)) |=> o_out.valid)
        else $error("finished result not presented");
`endif
endmodule
